### hdl/assert_macros.svh
// Assertion macros used by the checker file of the brush width block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### hdl/bsw_pkg.sv
// Package with the types and constants of the brush sample width block.
`timescale 1ns / 1ps
`default_nettype none
package bsw_pkg;

    localparam int LATENCY = 7;

    localparam logic [2:0] REG_MIN_WIDTH     = 3'd0;
    localparam logic [2:0] REG_MAX_WIDTH     = 3'd1;
    localparam logic [2:0] REG_INV_SPEED_REF = 3'd2;
    localparam logic [2:0] REG_NOISE_AMOUNT  = 3'd3;
    localparam logic [2:0] REG_INV_TAPER_LEN = 3'd4;
    localparam logic [2:0] REG_STROKE_SEED   = 3'd5;
    localparam logic [2:0] REG_FRAME_SEED    = 3'd6;

    localparam logic [15:0] RST_MIN_WIDTH     = 16'd461;
    localparam logic [15:0] RST_MAX_WIDTH     = 16'd2304;
    localparam logic [15:0] RST_INV_SPEED_REF = 16'd7282;
    localparam logic [15:0] RST_NOISE_AMOUNT  = 16'd9830;
    localparam logic [16:0] RST_INV_TAPER_LEN = 17'd7282;
    localparam logic [31:0] RST_STROKE_SEED   = 32'd0;
    localparam logic [31:0] RST_FRAME_SEED    = 32'd0;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [31:0] IDX_MUL = 32'h9E3779B1;
    localparam logic [31:0] MIX_C1  = 32'h7FEB352D;
    localparam logic [31:0] MIX_C2  = 32'h846CA68B;

    typedef struct packed {
        logic [15:0] min_width;
        logic [15:0] max_width;
        logic [15:0] inv_speed_ref;
        logic [15:0] noise_amount;
        logic [16:0] inv_taper_len;
        logic [31:0] stroke_seed;
        logic [31:0] frame_seed;
    } bsw_cfg_t;

endpackage
`default_nettype wire

### hdl/bsw_if.sv
// Valid/ready channel interfaces for sample input and width output.
`timescale 1ns / 1ps
`default_nettype none
interface bsw_in_if;
    logic        valid;
    logic        ready;
    logic [10:0] sample_index;
    logic [11:0] sample_count;
    logic [15:0] speed;

    modport source (output valid, output sample_index, output sample_count, output speed,
                    input ready);
    modport sink (input valid, input sample_index, input sample_count, input speed,
                  output ready);
endinterface

interface bsw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] width;

    modport source (output valid, output width, input ready);
    modport sink (input valid, input width, output ready);
endinterface
`default_nettype wire

### hdl/bsw_speed.sv
// Speed-dependent width: scale speed, clamp, and blend between max and min width.
`timescale 1ns / 1ps
`default_nettype none
module bsw_speed (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire bsw_pkg::bsw_cfg_t cfg,
    input  wire logic [15:0]      speed,
    output logic      [15:0]      ws
);

    logic [31:0] prod_reg, prod_next;
    logic [15:0] dq_reg, dq_next;
    logic [15:0] ws_reg, ws_next;
    logic [15:0] ws_d_reg;

    logic        ge;
    logic [16:0] sp;
    logic [15:0] diff;
    logic [32:0] dprod;

    always_comb
    begin
        prod_next = 32'(speed) * 32'(cfg.inv_speed_ref);
        ge = cfg.max_width >= cfg.min_width;
        if (prod_reg[31:8] > 24'(bsw_pkg::ONE_Q16))
        begin
            sp = bsw_pkg::ONE_Q16;
        end
        else
        begin
            sp = prod_reg[24:8];
        end
        diff = ge ? (cfg.max_width - cfg.min_width) : (cfg.min_width - cfg.max_width);
        dprod = 33'(diff) * 33'(sp);
        dq_next = dprod[31:16];
        ws_next = ge ? (cfg.max_width - dq_reg) : (cfg.max_width + dq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            dq_reg   <= dq_next;
            ws_reg   <= ws_next;
            ws_d_reg <= ws_reg;
        end
    end

    assign ws = ws_d_reg;

endmodule
`default_nettype wire

### hdl/bsw_taper.sv
// Stroke-end taper: distance to the nearer end, scaling, clamp and smoothstep.
`timescale 1ns / 1ps
`default_nettype none
module bsw_taper #(
    parameter int MAX_POINTS = 2048
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire bsw_pkg::bsw_cfg_t cfg,
    input  wire logic [10:0]      sample_index,
    input  wire logic [11:0]      sample_count,
    output logic      [16:0]      tap
);

    typedef struct packed {
        logic full;
        logic zero;
    } tap_flags_t;

    logic [10:0]  d_reg, d_next;
    logic [27:0]  tprod_reg, tprod_next;
    logic [16:0]  t_reg, t_next;
    logic [32:0]  t2_reg, t2_next;
    logic [16:0]  tap_reg, tap_next;
    tap_flags_t   fa_reg, fa_next;
    tap_flags_t   fb_reg;
    tap_flags_t   fc_reg;

    logic [11:0]        cnt_c;
    logic signed [12:0] a_s;
    logic signed [12:0] b_s;
    logic signed [12:0] d_s;
    logic [33:0]        t2_full;
    logic [17:0]        f;
    logic [50:0]        sprod;

    always_comb
    begin
        if ({5'd0, sample_count} > 17'(MAX_POINTS))
        begin
            cnt_c = 12'(MAX_POINTS);
        end
        else
        begin
            cnt_c = sample_count;
        end
        a_s = $signed({2'b00, sample_index});
        b_s = $signed({1'b0, cnt_c}) - 13'sd1 - a_s;
        d_s = (a_s < b_s) ? a_s : b_s;
        fa_next.full = cnt_c <= 12'd1;
        fa_next.zero = d_s[12] || (d_s == 13'sd0);
        d_next = d_s[10:0];

        tprod_next = 28'(d_reg) * 28'(cfg.inv_taper_len);

        if (tprod_reg > 28'(bsw_pkg::ONE_Q16))
        begin
            t_next = bsw_pkg::ONE_Q16;
        end
        else
        begin
            t_next = tprod_reg[16:0];
        end
        t2_full = 34'(t_next) * 34'(t_next);
        t2_next = t2_full[32:0];

        f = 18'(3 * 65536) - {t_reg, 1'b0};
        sprod = 51'(t2_reg) * 51'(f);
        if (fc_reg.full)
        begin
            tap_next = bsw_pkg::ONE_Q16;
        end
        else if (fc_reg.zero)
        begin
            tap_next = 17'd0;
        end
        else
        begin
            tap_next = sprod[48:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            fa_reg    <= fa_next;
            tprod_reg <= tprod_next;
            fb_reg    <= fa_reg;
            t_reg     <= t_next;
            t2_reg    <= t2_next;
            fc_reg    <= fb_reg;
            tap_reg   <= tap_next;
        end
    end

    assign tap = tap_reg;

endmodule
`default_nettype wire

### hdl/bsw_hash.sv
// Integer hash of seeds and index, and the wobble factor derived from it.
`timescale 1ns / 1ps
`default_nettype none
module bsw_hash (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire bsw_pkg::bsw_cfg_t cfg,
    input  wire logic [10:0]      sample_index,
    output logic      [40:0]      wob
);

    localparam logic [41:0] WOB_ONE = 42'h100_0000_0000;

    logic [31:0] x0_reg, x0_next;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] x2_reg, x2_next;
    logic [39:0] rn_reg, rn_next;
    logic [40:0] wob_reg, wob_next;

    logic [31:0] y1;
    logic [31:0] y2;
    logic [31:0] h;
    logic [41:0] wsum;

    always_comb
    begin
        x0_next = cfg.stroke_seed ^ cfg.frame_seed ^ (32'(sample_index) * bsw_pkg::IDX_MUL);
        y1 = x0_reg ^ (x0_reg >> 16);
        x1_next = y1 * bsw_pkg::MIX_C1;
        y2 = x1_reg ^ (x1_reg >> 15);
        x2_next = y2 * bsw_pkg::MIX_C2;
        h = x2_reg ^ (x2_reg >> 16);
        rn_next = 40'(h[23:0]) * 40'(cfg.noise_amount);
        wsum = WOB_ONE + {1'b0, rn_reg, 1'b0} - (42'(cfg.noise_amount) << 24);
        wob_next = wsum[40:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= x0_next;
            x1_reg  <= x1_next;
            x2_reg  <= x2_next;
            rn_reg  <= rn_next;
            wob_reg <= wob_next;
        end
    end

    assign wob = wob_reg;

endmodule
`default_nettype wire

### hdl/bsw_combine.sv
// Final product of speed width, taper and wobble, with saturation.
`timescale 1ns / 1ps
`default_nettype none
module bsw_combine (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] ws,
    input  wire logic [16:0] tap,
    input  wire logic [40:0] wob,
    output logic      [15:0] width
);

    logic [15:0] w1_reg, w1_next;
    logic [32:0] phi_reg, phi_next;
    logic [39:0] plo_reg, plo_next;
    logic [15:0] width_reg, width_next;

    logic [32:0] wt;
    logic [57:0] sum;

    always_comb
    begin
        wt = 33'(ws) * 33'(tap);
        w1_next = wt[31:16];
        phi_next = 33'(w1_reg) * 33'(wob[40:24]);
        plo_next = 40'(w1_reg) * 40'(wob[23:0]);
        sum = 58'({phi_reg, 24'd0}) + 58'(plo_reg);
        width_next = (|sum[57:56]) ? 16'hFFFF : sum[55:40];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg    <= w1_next;
            phi_reg   <= phi_next;
            plo_reg   <= plo_next;
            width_reg <= width_next;
        end
    end

    assign width = width_reg;

endmodule
`default_nettype wire

### hdl/brush_sample_width.sv
// Top level of the brush sample width pipeline with its configuration registers.
//
// Channel   Direction  Transfer when        Payload
// in_ch     sink       valid && ready       sample_index, sample_count, speed
// out_ch    source     valid && ready       width
// cfg       write      cfg_we               cfg_index, cfg_data
//
// One sample per cycle is accepted unless a result waits at the output.
// The latency is set by the seven register stages; the final width times wobble
// product is split over two of them.
// Reset clears the stage valid bits and loads the register defaults.
// While a result waits at the output, every stage holds and in_ch.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module brush_sample_width #(
    parameter int MAX_POINTS = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    bsw_in_if.sink           in_ch,
    bsw_out_if.source        out_ch
);

    localparam int LAT = bsw_pkg::LATENCY;

    bsw_pkg::bsw_cfg_t cfg_reg, cfg_next;
    logic [LAT-1:0]    valid_reg, valid_next;
    logic              en;

    logic [15:0] ws;
    logic [16:0] tap;
    logic [40:0] wob;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bsw_pkg::REG_MIN_WIDTH:     cfg_next.min_width = cfg_data[15:0];
                bsw_pkg::REG_MAX_WIDTH:     cfg_next.max_width = cfg_data[15:0];
                bsw_pkg::REG_INV_SPEED_REF: cfg_next.inv_speed_ref = cfg_data[15:0];
                bsw_pkg::REG_NOISE_AMOUNT:  cfg_next.noise_amount = cfg_data[15:0];
                bsw_pkg::REG_INV_TAPER_LEN: cfg_next.inv_taper_len = cfg_data[16:0];
                bsw_pkg::REG_STROKE_SEED:   cfg_next.stroke_seed = cfg_data;
                bsw_pkg::REG_FRAME_SEED:    cfg_next.frame_seed = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_width     <= bsw_pkg::RST_MIN_WIDTH;
            cfg_reg.max_width     <= bsw_pkg::RST_MAX_WIDTH;
            cfg_reg.inv_speed_ref <= bsw_pkg::RST_INV_SPEED_REF;
            cfg_reg.noise_amount  <= bsw_pkg::RST_NOISE_AMOUNT;
            cfg_reg.inv_taper_len <= bsw_pkg::RST_INV_TAPER_LEN;
            cfg_reg.stroke_seed   <= bsw_pkg::RST_STROKE_SEED;
            cfg_reg.frame_seed    <= bsw_pkg::RST_FRAME_SEED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign en = !valid_reg[LAT-1] || out_ch.ready;
    assign valid_next = {valid_reg[LAT-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ch.ready  = en;
    assign out_ch.valid = valid_reg[LAT-1];

    bsw_speed u_speed (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .speed (in_ch.speed),
        .ws    (ws)
    );

    bsw_taper #(
        .MAX_POINTS (MAX_POINTS)
    ) u_taper (
        .clk          (clk),
        .en           (en),
        .cfg          (cfg_reg),
        .sample_index (in_ch.sample_index),
        .sample_count (in_ch.sample_count),
        .tap          (tap)
    );

    bsw_hash u_hash (
        .clk          (clk),
        .en           (en),
        .cfg          (cfg_reg),
        .sample_index (in_ch.sample_index),
        .wob          (wob)
    );

    bsw_combine u_combine (
        .clk   (clk),
        .en    (en),
        .ws    (ws),
        .tap   (tap),
        .wob   (wob),
        .width (out_ch.width)
    );

endmodule
`default_nettype wire

### hdl/bsw_checker.sv
// Port-level checker for the brush sample width block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bsw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_width
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_width_hold, clk, rst_n, out_valid && !out_ready, $stable(out_width))
    `ASSERT_IMPLIES(a_ready_rule, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
    `ASSERT_IMPLIES(a_reset_empty, clk, rst_n, $rose(rst_n), !out_valid)

endmodule

bind brush_sample_width bsw_checker u_bsw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_width (out_ch.width)
);
`default_nettype wire

### dv/brush_sample_width_test.sv
// Self-checking testbench for the brush sample width pipeline.
`timescale 1ns / 1ps
module brush_sample_width_test;

    localparam int MAX_POINTS = 2048;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    bsw_in_if in_ch ();
    bsw_out_if out_ch ();

    brush_sample_width #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    bsw_pkg::bsw_cfg_t brush_cfg;
    logic [15:0] width_queue[$];
    bit no_idle = 1'b0;
    int error_count = 0;
    int samples_sent = 0;
    int widths_checked = 0;
    int settings_used = 1;
    int cycle_count = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] predict_width(input logic [10:0] idx,
                                                  input logic [11:0] cnt,
                                                  input logic [15:0] spd);
        logic [63:0] speed_frac;
        logic [63:0] speed_width;
        logic [63:0] ramp;
        logic [63:0] taper;
        logic [63:0] rnd;
        logic [63:0] wobble;
        logic [63:0] w;
        logic [31:0] h;
        int n;
        int a;
        int b;
        int d;
        speed_frac = (64'(spd) * 64'(brush_cfg.inv_speed_ref)) >> 8;
        if (speed_frac > 64'(bsw_pkg::ONE_Q16))
            speed_frac = 64'(bsw_pkg::ONE_Q16);
        if (brush_cfg.max_width >= brush_cfg.min_width)
            speed_width = 64'(brush_cfg.max_width)
                - ((64'(brush_cfg.max_width - brush_cfg.min_width) * speed_frac) >> 16);
        else
            speed_width = 64'(brush_cfg.max_width)
                + ((64'(brush_cfg.min_width - brush_cfg.max_width) * speed_frac) >> 16);

        n = (int'(cnt) > MAX_POINTS) ? MAX_POINTS : int'(cnt);
        if (n <= 1)
            taper = 64'(bsw_pkg::ONE_Q16);
        else
        begin
            a = int'(idx);
            b = n - 1 - int'(idx);
            d = (a < b) ? a : b;
            if (d <= 0)
                taper = 64'd0;
            else
            begin
                ramp = 64'(d) * 64'(brush_cfg.inv_taper_len);
                if (ramp > 64'(bsw_pkg::ONE_Q16))
                    ramp = 64'(bsw_pkg::ONE_Q16);
                taper = (ramp * ramp * (64'd196608 - 64'd2 * ramp)) >> 32;
            end
        end

        h = brush_cfg.stroke_seed ^ brush_cfg.frame_seed ^ (32'(idx) * bsw_pkg::IDX_MUL);
        h = h ^ (h >> 16);
        h = h * bsw_pkg::MIX_C1;
        h = h ^ (h >> 15);
        h = h * bsw_pkg::MIX_C2;
        h = h ^ (h >> 16);
        rnd = 64'(h[23:0]);
        wobble = (64'd1 << 40) + 64'd2 * rnd * 64'(brush_cfg.noise_amount)
            - (64'd1 << 24) * 64'(brush_cfg.noise_amount);

        w = (speed_width * taper) >> 16;
        w = (w * wobble) >> 40;
        if (w > 64'd65535)
            w = 64'd65535;
        return w[15:0];
    endfunction

    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            bsw_pkg::REG_MIN_WIDTH: brush_cfg.min_width = data[15:0];
            bsw_pkg::REG_MAX_WIDTH: brush_cfg.max_width = data[15:0];
            bsw_pkg::REG_INV_SPEED_REF: brush_cfg.inv_speed_ref = data[15:0];
            bsw_pkg::REG_NOISE_AMOUNT: brush_cfg.noise_amount = data[15:0];
            bsw_pkg::REG_INV_TAPER_LEN: brush_cfg.inv_taper_len = data[16:0];
            bsw_pkg::REG_STROKE_SEED: brush_cfg.stroke_seed = data;
            bsw_pkg::REG_FRAME_SEED: brush_cfg.frame_seed = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [10:0] idx, input logic [11:0] cnt,
                               input logic [15:0] spd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_index <= idx;
        in_ch.sample_count <= cnt;
        in_ch.speed <= spd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        width_queue.push_back(predict_width(idx, cnt, spd));
        samples_sent++;
    endtask

    task automatic wait_for_widths();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (width_queue.size() != 0);
    endtask

    task automatic send_random_sample();
        logic [10:0] idx;
        logic [11:0] cnt;
        logic [15:0] spd;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            cnt = 12'($urandom_range(2, 64));
        else if (pick < 15)
            cnt = 12'($urandom_range(2, MAX_POINTS));
        else if (pick < 17)
            cnt = 12'($urandom_range(0, 1));
        else
            cnt = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0 || cnt < 2 || cnt > MAX_POINTS)
            idx = 11'($urandom);
        else
            idx = 11'($urandom_range(0, int'(cnt) - 1));
        if ($urandom_range(0, 1) == 0)
            spd = 16'($urandom);
        else
            spd = 16'($urandom_range(0, 4095));
        send_sample(idx, cnt, spd);
    endtask

    task automatic apply_random_settings();
        logic [31:0] taper_len;
        int pick;
        write_reg(bsw_pkg::REG_MIN_WIDTH,
                  ($urandom_range(0, 4) == 0) ? 32'hFFFF : 32'($urandom_range(0, 4000)));
        write_reg(bsw_pkg::REG_MAX_WIDTH,
                  ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(0, 65535)));
        write_reg(bsw_pkg::REG_INV_SPEED_REF, 32'($urandom_range(0, 65535)));
        write_reg(bsw_pkg::REG_NOISE_AMOUNT,
                  ($urandom_range(0, 4) == 0) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 3);
        if (pick == 0)
            taper_len = 32'(bsw_pkg::ONE_Q16);
        else if (pick == 1)
            taper_len = 32'($urandom_range(0, 65536));
        else
            taper_len = 32'($urandom_range(1, 3000));
        write_reg(bsw_pkg::REG_INV_TAPER_LEN, taper_len);
        write_reg(bsw_pkg::REG_STROKE_SEED, $urandom);
        write_reg(bsw_pkg::REG_FRAME_SEED, $urandom);
        settings_used++;
    endtask

    task automatic test_default_settings();
        send_sample(11'd0, 12'd2048, 16'd0);
        send_sample(11'd1023, 12'd2048, 16'd0);
        send_sample(11'd2047, 12'd2048, 16'hFFFF);
        send_sample(11'd5, 12'd0, 16'd300);
        send_sample(11'd0, 12'd1, 16'd1200);
        send_sample(11'd100, 12'd4095, 16'd2303);
        send_sample(11'd2047, 12'd4095, 16'd50);
        send_sample(11'd10, 12'd5, 16'd100);
        wait_for_widths();
    endtask

    task automatic test_register_extremes();
        write_reg(bsw_pkg::REG_MIN_WIDTH, 32'hFFFF);
        write_reg(bsw_pkg::REG_MAX_WIDTH, 32'hFFFF);
        write_reg(bsw_pkg::REG_INV_SPEED_REF, 32'hFFFF);
        write_reg(bsw_pkg::REG_NOISE_AMOUNT, 32'hFFFF);
        write_reg(bsw_pkg::REG_INV_TAPER_LEN, 32'(bsw_pkg::ONE_Q16));
        write_reg(bsw_pkg::REG_STROKE_SEED, 32'hFFFF_FFFF);
        write_reg(bsw_pkg::REG_FRAME_SEED, 32'h5A5A_A5A5);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        settings_used++;
        send_sample(11'd1, 12'd3, 16'hFFFF);
        send_sample(11'd7, 12'd2048, 16'd0);
        send_sample(11'd0, 12'd1, 16'd1);
        send_sample(11'd2046, 12'd2048, 16'h8000);
        wait_for_widths();

        write_reg(bsw_pkg::REG_MIN_WIDTH, 32'hFFFF);
        write_reg(bsw_pkg::REG_MAX_WIDTH, 32'd0);
        write_reg(bsw_pkg::REG_NOISE_AMOUNT, 32'd0);
        write_reg(bsw_pkg::REG_STROKE_SEED, 32'd0);
        write_reg(bsw_pkg::REG_FRAME_SEED, 32'hFFFF_FFFF);
        settings_used++;
        send_sample(11'd9, 12'd20, 16'd0);
        send_sample(11'd9, 12'd20, 16'd128);
        send_sample(11'd9, 12'd20, 16'd255);
        send_sample(11'd9, 12'd20, 16'hFFFF);
        wait_for_widths();

        write_reg(bsw_pkg::REG_INV_SPEED_REF, 32'd0);
        write_reg(bsw_pkg::REG_INV_TAPER_LEN, 32'd0);
        write_reg(bsw_pkg::REG_MAX_WIDTH, 32'd2304);
        settings_used++;
        send_sample(11'd500, 12'd1000, 16'hFFFF);
        send_sample(11'd0, 12'd0, 16'hFFFF);
        send_sample(11'd1024, 12'd2049, 16'd0);
        wait_for_widths();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            no_idle = (phase == 2 || phase == 6);
            apply_random_settings();
            for (int k = 0; k < 100; k++)
                send_random_sample();
            wait_for_widths();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            if (width_queue.size() == 0)
            begin
                $error("width transfer with nothing expected: actual %0d", out_ch.width);
                error_count++;
            end
            else
            begin
                if (out_ch.width !== width_queue[0])
                begin
                    $error("width mismatch: expected %0d, actual %0d",
                           width_queue[0], out_ch.width);
                    error_count++;
                end
                void'(width_queue.pop_front());
                widths_checked++;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bsw_pkg::REG_MIN_WIDTH;
        cfg_data <= 32'd0;
        in_ch.valid <= 1'b0;
        in_ch.sample_index <= 11'd0;
        in_ch.sample_count <= 12'd0;
        in_ch.speed <= 16'd0;
        brush_cfg.min_width = bsw_pkg::RST_MIN_WIDTH;
        brush_cfg.max_width = bsw_pkg::RST_MAX_WIDTH;
        brush_cfg.inv_speed_ref = bsw_pkg::RST_INV_SPEED_REF;
        brush_cfg.noise_amount = bsw_pkg::RST_NOISE_AMOUNT;
        brush_cfg.inv_taper_len = bsw_pkg::RST_INV_TAPER_LEN;
        brush_cfg.stroke_seed = bsw_pkg::RST_STROKE_SEED;
        brush_cfg.frame_seed = bsw_pkg::RST_FRAME_SEED;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_register_extremes();
        test_random_settings();

        repeat (bsw_pkg::LATENCY + 4) @(posedge clk);
        if (width_queue.size() != 0)
        begin
            $error("%0d expected widths never arrived", width_queue.size());
            error_count++;
        end
        $display("Sent %0d samples under %0d register settings; %0d widths compared.",
                 samples_sent, settings_used, widths_checked);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
